/* rtl/core/ils_pkg.sv */
// Shared types and constants for the indexed list store.
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

  // Default list depth
  localparam int ILS_CAPACITY = 16;

  // Fixed field widths
  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int CMD_W    = 3;
  // Positions that the position field can name
  localparam int POS_SPAN = 1 << POS_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

  // Result status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cell operation broadcast to the whole row
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_WRITE  = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  value;
  } cell_ctrl_t;

  // Channel payloads
  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  value_out;
    logic [COUNT_W-1:0]        count;
    status_t                   status;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/core/ils_cell.sv */
// One storage cell of the list row: holds one entry, shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module ils_cell #(
  parameter int IDX  = 0,
  parameter int IDXW = 4
) (
  input  logic                              clk,
  input  ils_pkg::cell_ctrl_t               ctrl,
  input  logic [IDXW-1:0]                   wr_idx,
  input  logic signed [ils_pkg::DATA_W-1:0] left_q,
  input  logic signed [ils_pkg::DATA_W-1:0] right_q,
  output logic signed [ils_pkg::DATA_W-1:0] q
);
  import ils_pkg::*;

  logic signed [DATA_W-1:0] q_r;
  logic signed [DATA_W-1:0] q_nxt;
  logic                     at_idx;
  logic                     above_idx;

  // Position of this cell relative to the target index
  assign at_idx    = (IDXW'(IDX) == wr_idx);
  assign above_idx = (IDXW'(IDX) > wr_idx);

  // Next entry: write here, take left neighbor (insert) or right neighbor (remove)
  always_comb begin
    q_nxt = q_r;
    unique case (ctrl.op)
      CELL_HOLD: begin
        q_nxt = q_r;
      end
      CELL_WRITE: begin
        if (at_idx) q_nxt = ctrl.value;
      end
      CELL_INSERT: begin
        if (at_idx) q_nxt = ctrl.value;
        else if (above_idx) q_nxt = left_q;
      end
      CELL_REMOVE: begin
        if (at_idx || above_idx) q_nxt = right_q;
      end
      default: begin
        q_nxt = q_r;
      end
    endcase
  end

  // Entry storage, payload only
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

/* rtl/core/indexed_list_store.sv */
// Top level of the indexed list store: command decode, cell row and result register.
//
// Ordered list of up to CAPACITY signed 32-bit entries kept in a row of cells.
// Every transaction (get, set, add, insert, remove) is decoded against the element
// count and broadcast to all cells, and insert or remove moves every later entry
// one cell in the same edge. A single result register holds the answer, so one
// transaction per cycle is sustained while the result side keeps up; the input
// stalls only while a result waits under out_stall. out_valid rises in the cycle
// after acceptance. No clearing pass after reset: entries are only read below the
// count, where they have been written. Positions are 4 bits, so only the first 16
// entries can be addressed by get, set, insert and remove; count reports the
// low 5 bits.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_store #(
  parameter int CAPACITY = ils_pkg::ILS_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ils_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ils_pkg::out_item_t out_data
);
  import ils_pkg::*;

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int RDN  = (CAPACITY < POS_SPAN) ? CAPACITY : POS_SPAN;

  logic [CNTW-1:0]          count_r;
  logic [CNTW-1:0]          count_nxt;
  logic                     out_valid_r;
  out_item_t                out_data_r;
  logic                     accept;
  logic                     in_range;
  logic                     full;
  logic signed [DATA_W-1:0] rd_word;
  cell_op_t                 op;
  cell_ctrl_t               ctrl;
  logic [IDXW-1:0]          wr_idx;
  out_item_t                res;
  logic signed [DATA_W-1:0] q [CAPACITY];
  logic signed [DATA_W-1:0] left_w [CAPACITY];
  logic signed [DATA_W-1:0] right_w [CAPACITY];

  // Handshake: take a transaction unless a finished result is held
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign in_range = (int'(in_data.position) < int'(count_r));
  assign full     = (count_r == CNTW'(CAPACITY));

  // Read port over the addressable cells
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < RDN; i++) begin
      if (in_data.position == POS_W'(i)) rd_word = q[i];
    end
  end

  // Command decode
  always_comb begin
    op            = CELL_HOLD;
    wr_idx        = IDXW'(in_data.position);
    count_nxt     = count_r;
    res.value_out = '0;
    res.status    = ST_OK;
    unique case (in_data.command)
      CMD_GET: begin
        if (in_range) res.value_out = rd_word;
        else res.status = ST_RANGE;
      end
      CMD_SET: begin
        if (in_range) op = CELL_WRITE;
        else res.status = ST_RANGE;
      end
      CMD_ADD: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          op        = CELL_WRITE;
          wr_idx    = IDXW'(count_r);
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_INSERT: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else if (full) begin
          res.status = ST_FULL;
        end else begin
          op        = CELL_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else begin
          res.value_out = rd_word;
          op            = CELL_REMOVE;
          count_nxt     = count_r - 1'b1;
        end
      end
      default: begin
        op = CELL_HOLD;
      end
    endcase
    res.count = COUNT_W'(count_nxt);
  end

  // Broadcast to the row only on an accepted transaction
  assign ctrl.op    = accept ? op : CELL_HOLD;
  assign ctrl.value = in_data.value_in;

  // Row of cells with neighbor links
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = in_data.value_in;
    end else begin : g_mid_l
      assign left_w[g] = q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w[g] = q[g];
    end else begin : g_mid_r
      assign right_w[g] = q[g+1];
    end

    ils_cell #(
      .IDX  (g),
      .IDXW (IDXW)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .wr_idx  (wr_idx),
      .left_q  (left_w[g]),
      .right_q (right_w[g]),
      .q       (q[g])
    );
  end

  // Element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(CAPACITY))
    else $error("element count above capacity");

  // An add or insert rejected as full leaves the count alone
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res.status == ST_FULL |=> count_r == $past(count_r))
    else $error("count changed on full list");

  // A successful add grows the list by one
  a_add_grow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.command == CMD_ADD && res.status == ST_OK
    |=> count_r == CNTW'($past(count_r) + 1'b1))
    else $error("add did not grow the list");

  // Input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no result held");

  // Errors carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != ST_OK |-> out_data_r.value_out == '0)
    else $error("nonzero value on error result");

endmodule

`default_nettype wire
